// ----- src/mvpi_pkg.sv -----
// Shared types and constants for the matrix-vector block.
// No dependencies; imported by every module of the block except the RAM.
`default_nettype none

package mvpi_pkg;

    localparam int MAX_DIM = 64;
    // Dimensions actually addressable through the 6-bit index fields
    localparam int LIM     = (MAX_DIM < 64) ? MAX_DIM : 64;
    localparam int IDX_W   = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int MAT_AW  = 2 * IDX_W;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    // 64 products of up to 2^62 plus the added element, with sign
    localparam int ACC_W   = 72;
    localparam int SIZE_W  = 7;
    localparam int FIELD_W = 6;

    typedef enum logic [1:0] {
        CMD_LOAD_MAT = 2'd0,
        CMD_LOAD_VEC = 2'd1,
        CMD_START    = 2'd2
    } t_cmd;

    // One beat of work issued to the multiply-accumulate unit
    typedef struct packed {
        logic             vld;
        logic             init;
        logic             last;
        logic             phase;
        logic [IDX_W-1:0] row;
    } t_tok;

    // Finished row result handed back for write-back
    typedef struct packed {
        logic              vld;
        logic              phase;
        logic [IDX_W-1:0]  row;
        logic [DATA_W-1:0] data;
    } t_wb;

endpackage

`default_nettype wire

// ----- src/mvpi_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module mvpi_ram #(
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/mvpi_mac.sv -----
// Multiply-accumulate datapath: product stage, accumulator, Q16.16 saturation.
// Depends on mvpi_pkg for the token and write-back types.
`default_nettype none

module mvpi_mac import mvpi_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tok              i_tok,
    input  wire logic [DATA_W-1:0] i_mat,
    input  wire logic [DATA_W-1:0] i_vec,
    input  wire logic [DATA_W-1:0] i_mid,
    output t_wb                    o_wb
);

    localparam int HI_LSB = DATA_W + FRAC_W - 1;

    t_tok                    r_tok1;
    t_tok                    r_tok2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic        [DATA_W-1:0] src;
    logic        [ACC_W-1:HI_LSB] acc_hi;
    logic        [DATA_W-1:0] sat;

    // Source vector is v in the first pass and y in the second
    assign src = i_tok.phase ? i_mid : i_vec;

    always_comb begin
        if (i_tok.init) begin
            // Added element moved to Q32.32
            n_prod = {{(PROD_W-DATA_W-FRAC_W){src[DATA_W-1]}}, src, {FRAC_W{1'b0}}};
        end else begin
            n_prod = $signed(i_mat) * $signed(src);
        end
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= '0;
            r_tok2 <= '0;
        end else begin
            r_tok1 <= i_tok;
            r_tok2 <= r_tok1;
        end
        if (i_tok.vld) begin
            r_prod <= n_prod;
        end
        if (r_tok1.vld) begin
            r_acc <= r_tok1.init ? prod_ext : r_acc + prod_ext;
        end
    end

    // Floor to Q16.16, clamp when the upper bits are not all sign
    assign acc_hi = r_acc[ACC_W-1:HI_LSB];

    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            sat = r_acc[HI_LSB:FRAC_W];
        end else if (r_acc[ACC_W-1]) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        o_wb.vld   = r_tok2.vld && r_tok2.last;
        o_wb.phase = r_tok2.phase;
        o_wb.row   = r_tok2.row;
        o_wb.data  = sat;
    end

endmodule

`default_nettype wire

// ----- src/mvpi_seq.sv -----
// Sequencer: load decode, size register, row/column walk over the stores,
// write-back of finished rows and the result output register. Uses mvpi_pkg.
`default_nettype none

module mvpi_seq import mvpi_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [FIELD_W-1:0] i_row,
    input  wire logic [FIELD_W-1:0] i_col,
    input  wire logic [DATA_W-1:0]  i_value,
    // size register
    input  wire logic               i_cfg_we,
    input  wire logic [SIZE_W-1:0]  i_cfg_wdata,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [FIELD_W-1:0]      o_index,
    output logic [DATA_W-1:0]       o_result,
    output logic                    o_last,
    // store ports
    output logic                    o_mat_we,
    output logic [MAT_AW-1:0]       o_mat_waddr,
    output logic [MAT_AW-1:0]       o_mat_raddr,
    output logic                    o_vec_we,
    output logic [IDX_W-1:0]        o_vec_waddr,
    output logic [DATA_W-1:0]       o_vec_wdata,
    output logic                    o_mid_we,
    output logic [IDX_W-1:0]        o_src_raddr,
    // datapath
    output t_tok                    o_tok,
    input  wire t_wb                i_wb
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state             r_state, n_state;
    logic               r_phase, n_phase;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;
    logic               r_in_row, n_in_row;
    logic               r_busy, n_busy;
    logic [IDX_W-1:0]   r_nm1, n_nm1;
    logic [SIZE_W-1:0]  r_size;
    t_tok               r_tok, n_tok;
    logic               r_out_vld, n_out_vld;
    logic [FIELD_W-1:0] r_out_idx;
    logic [DATA_W-1:0]  r_out_res;
    logic               r_out_last;

    logic               accept;
    logic               row_ok;
    logic               col_ok;
    logic [SIZE_W-1:0]  n_clamped;
    logic               out_load;

    assign o_stall = (r_state != S_IDLE) || r_busy;
    assign accept  = i_valid && !o_stall;
    assign row_ok  = {1'b0, i_row} < SIZE_W'(LIM);
    assign col_ok  = {1'b0, i_col} < SIZE_W'(LIM);

    always_comb begin
        if (r_size == '0) begin
            n_clamped = SIZE_W'(1);
        end else if (r_size > SIZE_W'(LIM)) begin
            n_clamped = SIZE_W'(LIM);
        end else begin
            n_clamped = r_size;
        end
    end

    assign out_load = i_wb.vld && i_wb.phase;

    // Store ports
    assign o_mat_waddr = {i_row[IDX_W-1:0], i_col[IDX_W-1:0]};
    assign o_mat_raddr = {r_row, r_col};
    assign o_src_raddr = r_in_row ? r_col : r_row;
    assign o_vec_waddr = i_wb.vld ? i_wb.row : i_row[IDX_W-1:0];
    assign o_vec_wdata = i_wb.vld ? i_wb.data : i_value;
    assign o_mid_we    = i_wb.vld && !i_wb.phase;

    always_comb begin
        o_mat_we = 1'b0;
        o_vec_we = out_load;
        if (accept) begin
            unique case (t_cmd'(i_command))
                CMD_LOAD_MAT: o_mat_we = row_ok && col_ok;
                CMD_LOAD_VEC: o_vec_we = row_ok;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_row     = r_row;
        n_col     = r_col;
        n_in_row  = r_in_row;
        n_busy    = r_busy;
        n_nm1     = r_nm1;
        n_tok     = '0;
        n_out_vld = r_out_vld;

        // Drop the row interlock once its result is written back
        if (i_wb.vld) begin
            n_busy = 1'b0;
        end

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_cmd'(i_command) == CMD_START)) begin
                    n_state  = S_RUN;
                    n_phase  = 1'b0;
                    n_row    = '0;
                    n_in_row = 1'b0;
                    n_nm1    = IDX_W'(n_clamped - SIZE_W'(1));
                end
            end
            S_RUN: begin
                if (!r_in_row) begin
                    // Second pass holds each row until the output slot is free
                    if (!r_busy && (!r_phase || !r_out_vld)) begin
                        n_tok.vld   = 1'b1;
                        n_tok.init  = 1'b1;
                        n_tok.phase = r_phase;
                        n_tok.row   = r_row;
                        n_in_row    = 1'b1;
                        n_col       = '0;
                        n_busy      = 1'b1;
                    end
                end else begin
                    n_tok.vld   = 1'b1;
                    n_tok.last  = (r_col == r_nm1);
                    n_tok.phase = r_phase;
                    n_tok.row   = r_row;
                    n_col       = r_col + IDX_W'(1);
                    if (r_col == r_nm1) begin
                        n_in_row = 1'b0;
                        if (r_row == r_nm1) begin
                            n_row = '0;
                            if (!r_phase) begin
                                n_phase = 1'b1;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_row = r_row + IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_in_row  <= 1'b0;
            r_busy    <= 1'b0;
            r_nm1     <= '0;
            r_size    <= SIZE_W'(64);
            r_tok     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_col     <= n_col;
            r_in_row  <= n_in_row;
            r_busy    <= n_busy;
            r_nm1     <= n_nm1;
            r_tok     <= n_tok;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
        if (out_load) begin
            r_out_idx  <= FIELD_W'(i_wb.row);
            r_out_res  <= i_wb.data;
            r_out_last <= (i_wb.row == r_nm1);
        end
    end

    assign o_tok    = r_tok;
    assign o_valid  = r_out_vld;
    assign o_index  = r_out_idx;
    assign o_result = r_out_res;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire

// ----- src/matrix_vector_plus_identity_twice.sv -----
// Top level: x = A*y + y with y = A*v + v over stored A and v, Q16.16.
// Depends on mvpi_pkg, mvpi_ram, mvpi_mac and mvpi_seq.
//
//   channel | handshake               | beat contents
//   --------+-------------------------+-----------------------------------
//   in      | i_valid / o_stall       | i_command, i_row, i_col, i_value
//   out     | o_valid / i_stall       | o_index, o_result, o_last
//   cfg     | i_cfg_we                | i_cfg_wdata (size in use)
//
// A start runs two passes of n rows; each row issues one read of the
// matrix store per cycle through the single MAC, then a write-back.
// Second-pass rows also wait while the output register holds an untaken beat.
// Reset is synchronous; stores are not cleared and size resets to 64.
// o_stall stays high from the start beat until the last row is written back.
`default_nettype none

module matrix_vector_plus_identity_twice import mvpi_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [1:0]               i_command,
    input  wire logic [FIELD_W-1:0]       i_row,
    input  wire logic [FIELD_W-1:0]       i_col,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_cfg_we,
    input  wire logic [SIZE_W-1:0]        i_cfg_wdata,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [FIELD_W-1:0]            o_index,
    output logic signed [DATA_W-1:0]      o_result,
    output logic                          o_last
);

    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr;
    logic [MAT_AW-1:0] mat_raddr;
    logic              vec_we;
    logic [IDX_W-1:0]  vec_waddr;
    logic [DATA_W-1:0] vec_wdata;
    logic              mid_we;
    logic [IDX_W-1:0]  src_raddr;
    logic [DATA_W-1:0] mat_q;
    logic [DATA_W-1:0] vec_q;
    logic [DATA_W-1:0] mid_q;
    logic [DATA_W-1:0] result;
    t_tok              tok;
    t_wb               wb;

    mvpi_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_index     (o_index),
        .o_result    (result),
        .o_last      (o_last),
        .o_mat_we    (mat_we),
        .o_mat_waddr (mat_waddr),
        .o_mat_raddr (mat_raddr),
        .o_vec_we    (vec_we),
        .o_vec_waddr (vec_waddr),
        .o_vec_wdata (vec_wdata),
        .o_mid_we    (mid_we),
        .o_src_raddr (src_raddr),
        .o_tok       (tok),
        .i_wb        (wb)
    );

    assign o_result = $signed(result);

    mvpi_ram #(.ADDR_W(MAT_AW), .WIDTH(DATA_W)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (i_value),
        .i_raddr (mat_raddr),
        .o_rdata (mat_q)
    );

    mvpi_ram #(.ADDR_W(IDX_W), .WIDTH(DATA_W)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (vec_wdata),
        .i_raddr (src_raddr),
        .o_rdata (vec_q)
    );

    mvpi_ram #(.ADDR_W(IDX_W), .WIDTH(DATA_W)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (wb.row),
        .i_wdata (wb.data),
        .i_raddr (src_raddr),
        .o_rdata (mid_q)
    );

    mvpi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok),
        .i_mat   (mat_q),
        .i_vec   (vec_q),
        .i_mid   (mid_q),
        .o_wb    (wb)
    );

endmodule

`default_nettype wire
